FILE: hdl/bms_pkg.sv
// Shared types, constants and helper functions for the button mode sequencer.
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

  localparam int unsigned ModeCountDefault = 9;
  localparam int unsigned FrameModes       = 9;

  localparam logic [15:0] LongPressReset  = 16'd1000;
  localparam logic [15:0] ShortPressReset = 16'd50;
  localparam logic [15:0] AdcPeriodReset  = 16'd500;
  localparam logic [11:0] LowBatteryReset = 12'd2700;
  localparam logic [31:0] AutoSwitchReset = 32'd45000;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_LONG_PRESS  = 3'd0,
    CFG_SHORT_PRESS = 3'd1,
    CFG_ADC_PERIOD  = 3'd2,
    CFG_LOW_BATTERY = 3'd3,
    CFG_AUTO_SWITCH = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_level;
    logic        adc_ready;
    logic [11:0] adc_sample;
  } poll_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       mode_changed;
    logic       needs_init;
    logic       frame_tick;
    logic       power_off;
    logic       auto_enabled;
  } result_t;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] short_press_min_ms;
    logic [15:0] adc_period_ms;
    logic [11:0] low_battery_level;
    logic [31:0] auto_switch_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  mode_now;
    logic [31:0] mode_start_time;
    logic [31:0] frame_start_time;
    logic [31:0] press_start_time;
    logic        last_button;
    logic        auto_on;
    logic [31:0] adc_check_time;
    logic        halted;
  } state_t;

  // Frame interval in ms for each mode; modes past the table have none.
  function automatic logic [7:0] frame_ms(input logic [3:0] mode);
    logic [7:0] ms;
    case (mode)
      4'd0:    ms = 8'd30;
      4'd1:    ms = 8'd50;
      4'd2:    ms = 8'd220;
      4'd3:    ms = 8'd30;
      4'd4:    ms = 8'd60;
      4'd5:    ms = 8'd80;
      4'd6:    ms = 8'd40;
      4'd7:    ms = 8'd30;
      4'd8:    ms = 8'd30;
      default: ms = 8'd0;
    endcase
    return ms;
  endfunction

  function automatic logic has_frame(input logic [3:0] mode);
    return {1'b0, mode} < 5'(FrameModes);
  endfunction

  // Modes whose animation restarts from scratch on entry.
  function automatic logic mode_needs_init(input logic [3:0] mode);
    return mode inside {4'd0, 4'd1, 4'd2, 4'd5, 4'd6, 4'd8};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/button_mode_sequencer.sv
// Top level of the button mode sequencer: handshakes, configuration and state.
// An accepted transaction lands in the input register, and its result is then
// registered in the output register and presented from there.
// Throughput: one poll per cycle; the single-pass step logic between the input
// and output registers sets that figure, and input stalls only on output stall.
// Reset: clears all state (auto switching on, mode 0, not powered off) and loads
// the configuration defaults; no transaction is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none

module button_mode_sequencer #(
  parameter int unsigned MODE_COUNT = bms_pkg::ModeCountDefault
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  bms_pkg::poll_t                       in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output bms_pkg::result_t                     out_data_o,
  input  wire                                  cfg_we_i,
  input  wire  [bms_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  wire  [bms_pkg::CfgDataWidth-1:0]     cfg_wdata_i
);

  bms_pkg::cfg_t    cfg_q;
  bms_pkg::state_t  state_q;
  bms_pkg::state_t  state_d;
  bms_pkg::poll_t   poll_q;
  bms_pkg::result_t result_d;
  bms_pkg::result_t result_q;
  logic             poll_valid_q;
  logic             out_valid_q;
  logic             out_free;
  logic             advance;
  logic             in_accept;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Move the buffered poll into the output register, committing its state.
  assign advance    = poll_valid_q && out_free;
  // Hold off new input only while the input register is full and cannot move.
  assign in_stall_o = poll_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms      <= bms_pkg::LongPressReset;
      cfg_q.short_press_min_ms <= bms_pkg::ShortPressReset;
      cfg_q.adc_period_ms      <= bms_pkg::AdcPeriodReset;
      cfg_q.low_battery_level  <= bms_pkg::LowBatteryReset;
      cfg_q.auto_switch_ms     <= bms_pkg::AutoSwitchReset;
    end else if (cfg_we_i) begin
      case (bms_pkg::cfg_idx_e'(cfg_idx_i))
        bms_pkg::CFG_LONG_PRESS:  cfg_q.long_press_ms      <= cfg_wdata_i[15:0];
        bms_pkg::CFG_SHORT_PRESS: cfg_q.short_press_min_ms <= cfg_wdata_i[15:0];
        bms_pkg::CFG_ADC_PERIOD:  cfg_q.adc_period_ms      <= cfg_wdata_i[15:0];
        bms_pkg::CFG_LOW_BATTERY: cfg_q.low_battery_level  <= cfg_wdata_i[11:0];
        bms_pkg::CFG_AUTO_SWITCH: cfg_q.auto_switch_ms     <= cfg_wdata_i;
        default: begin
          // Drop writes to unused indexes.
        end
      endcase
    end
  end

  // Input register: valid bit under reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_valid_q <= 1'b0;
    end else if (in_accept) begin
      poll_valid_q <= 1'b1;
    end else if (advance) begin
      poll_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      poll_q <= in_data_i;
    end
  end

  bms_step #(
    .MODE_COUNT(MODE_COUNT)
  ) u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .poll_i  (poll_q),
    .state_o (state_d),
    .result_o(result_d)
  );

  // Sequencer state advances once per poll, when its result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{auto_on: 1'b1, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= poll_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bms_step.sv
// Next-state and result logic for one poll of the button mode sequencer.
`timescale 1ns / 1ps
`default_nettype none

module bms_step #(
  parameter int unsigned MODE_COUNT = bms_pkg::ModeCountDefault
) (
  input  bms_pkg::state_t  state_i,
  input  bms_pkg::cfg_t    cfg_i,
  input  bms_pkg::poll_t   poll_i,
  output bms_pkg::state_t  state_o,
  output bms_pkg::result_t result_o
);

  logic [31:0] press_dt;
  logic [31:0] adc_dt;
  logic [31:0] auto_dt;
  logic [31:0] frame_dt;
  logic [3:0]  mode_inc;
  logic [3:0]  mode_next;
  logic        rise;
  logic        held;
  logic        fall;
  logic        long_hold;
  logic        release_adv;
  logic        adc_due;
  logic        low_batt;
  logic        auto_adv;
  logic        advance;
  logic [3:0]  mode_after;
  logic        tick;

  assign press_dt = poll_i.now_ms - state_i.press_start_time;
  assign adc_dt   = poll_i.now_ms - state_i.adc_check_time;
  assign auto_dt  = poll_i.now_ms - state_i.mode_start_time;
  assign frame_dt = poll_i.now_ms - state_i.frame_start_time;

  assign mode_inc  = state_i.mode_now + 4'd1;
  assign mode_next = ({1'b0, mode_inc} >= 5'(MODE_COUNT)) ? 4'd0 : mode_inc;

  assign rise = poll_i.button_level & ~state_i.last_button;
  assign held = poll_i.button_level & state_i.last_button;
  assign fall = ~poll_i.button_level & state_i.last_button;

  assign long_hold   = held && (press_dt > {16'd0, cfg_i.long_press_ms});
  assign release_adv = fall && (press_dt > {16'd0, cfg_i.short_press_min_ms})
                       && (press_dt <= {16'd0, cfg_i.long_press_ms});

  assign adc_due  = adc_dt >= {16'd0, cfg_i.adc_period_ms};
  assign low_batt = adc_due && poll_i.adc_ready
                    && (poll_i.adc_sample < cfg_i.low_battery_level);

  // A manual advance turns auto switching off and blocks the auto advance, so at most one advance per poll.
  assign auto_adv = state_i.auto_on && !release_adv && !low_batt
                    && (auto_dt >= cfg_i.auto_switch_ms);
  assign advance    = release_adv || auto_adv;
  assign mode_after = advance ? mode_next : state_i.mode_now;

  assign tick = !low_batt && bms_pkg::has_frame(mode_after)
                && (frame_dt >= {24'd0, bms_pkg::frame_ms(mode_after)});

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.halted) begin
      result_o.mode         = state_i.mode_now;
      result_o.power_off    = 1'b1;
      result_o.auto_enabled = state_i.auto_on;
    end else if (long_hold) begin
      // Power off right away; leave everything else as it was.
      state_o.halted        = 1'b1;
      result_o.mode         = state_i.mode_now;
      result_o.power_off    = 1'b1;
      result_o.auto_enabled = state_i.auto_on;
    end else begin
      if (rise) begin
        state_o.press_start_time = poll_i.now_ms;
      end
      if (release_adv) begin
        state_o.auto_on = 1'b0;
      end
      state_o.last_button = poll_i.button_level;
      if (adc_due) begin
        state_o.adc_check_time = poll_i.now_ms;
      end
      if (low_batt) begin
        state_o.halted = 1'b1;
      end
      if (auto_adv) begin
        state_o.mode_start_time = poll_i.now_ms;
      end
      if (tick) begin
        state_o.frame_start_time = poll_i.now_ms;
      end
      state_o.mode_now = mode_after;

      result_o.mode         = mode_after;
      result_o.mode_changed = advance;
      result_o.needs_init   = advance && bms_pkg::mode_needs_init(mode_after);
      result_o.frame_tick   = tick;
      result_o.power_off    = low_batt;
      result_o.auto_enabled = state_o.auto_on;
    end
  end

endmodule

`default_nettype wire

FILE: sim/button_mode_sequencer_checker.sv
// Checker for the button mode sequencer: mirrors the block's state and compares every result.
`timescale 1ns / 1ps

module button_mode_sequencer_checker #(
  parameter int unsigned MODE_COUNT = bms_pkg::ModeCountDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             poll_valid_i,
  input  logic                             poll_stall_i,
  input  bms_pkg::poll_t                   poll_i,
  input  logic                             result_valid_i,
  input  logic                             result_stall_i,
  input  bms_pkg::result_t                 result_i,
  input  logic                             cfg_we_i,
  input  logic [bms_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [bms_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  output int unsigned                      mismatches_o,
  output int unsigned                      outstanding_o,
  output int unsigned                      checked_o,
  output int unsigned                      advances_o
);

  localparam int unsigned FRAME_MODES = 9;

  logic [7:0]  frame_period [FRAME_MODES];
  logic [15:0] long_ms, short_ms, adc_ms;
  logic [11:0] low_level;
  logic [31:0] auto_ms;
  logic [3:0]  mode_q;
  logic [31:0] mode_stamp, frame_stamp, press_stamp, battery_stamp;
  logic        btn_last, auto_on, powered_off;
  bms_pkg::result_t expected_q [$];
  bms_pkg::result_t want;
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned advances = 0;

  initial frame_period = '{8'd30, 8'd50, 8'd220, 8'd30, 8'd60, 8'd80, 8'd40, 8'd30, 8'd30};

  // Step to the next mode, wrapping at MODE_COUNT; report whether it restarts its animation.
  function automatic logic advance_mode();
    logic [3:0] next;
    next = mode_q + 4'd1;
    if (next >= MODE_COUNT) next = '0;
    mode_q = next;
    case (next)
      4'd0, 4'd1, 4'd2, 4'd5, 4'd6, 4'd8: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bms_pkg::result_t predict_poll(input bms_pkg::poll_t p);
    bms_pkg::result_t r;
    logic [31:0] since_press, since_check, since_mode, since_frame;
    since_press = p.now_ms - press_stamp;
    since_check = p.now_ms - battery_stamp;
    since_mode  = p.now_ms - mode_stamp;
    since_frame = p.now_ms - frame_stamp;
    r = '0;
    if (!powered_off) begin
      if (p.button_level && !btn_last) begin
        press_stamp = p.now_ms;
      end else if (p.button_level && btn_last) begin
        if (since_press > {16'd0, long_ms}) powered_off = 1'b1;
      end else if (!p.button_level && btn_last) begin
        if (since_press > {16'd0, short_ms} && since_press <= {16'd0, long_ms}) begin
          r.needs_init   = advance_mode();
          r.mode_changed = 1'b1;
          auto_on        = 1'b0;
        end
      end
      if (!powered_off) begin
        btn_last = p.button_level;
        if (since_check >= {16'd0, adc_ms}) begin
          battery_stamp = p.now_ms;
          if (p.adc_ready && p.adc_sample < low_level) powered_off = 1'b1;
        end
      end
      // a shutdown in this poll skips the auto advance and the frame timer
      if (!powered_off) begin
        if (auto_on && since_mode >= auto_ms) begin
          r.needs_init   = advance_mode();
          r.mode_changed = 1'b1;
          mode_stamp     = p.now_ms;
        end
        if (mode_q < FRAME_MODES) begin
          if (since_frame >= {24'd0, frame_period[mode_q]}) begin
            r.frame_tick = 1'b1;
            frame_stamp  = p.now_ms;
          end
        end
      end
    end
    r.mode         = mode_q;
    r.power_off    = powered_off;
    r.auto_enabled = auto_on;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [3:0] exp_val,
                               input logic [3:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ms       = bms_pkg::LongPressReset;
      short_ms      = bms_pkg::ShortPressReset;
      adc_ms        = bms_pkg::AdcPeriodReset;
      low_level     = bms_pkg::LowBatteryReset;
      auto_ms       = bms_pkg::AutoSwitchReset;
      mode_q        = '0;
      mode_stamp    = '0;
      frame_stamp   = '0;
      press_stamp   = '0;
      battery_stamp = '0;
      btn_last      = 1'b0;
      auto_on       = 1'b1;
      powered_off   = 1'b0;
      expected_q.delete();
    end else begin
      if (result_valid_i && !result_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction arrived with no poll outstanding");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          compare_field("mode", want.mode, result_i.mode);
          compare_field("mode_changed", 4'(want.mode_changed),
                        4'(result_i.mode_changed));
          compare_field("needs_init", 4'(want.needs_init), 4'(result_i.needs_init));
          compare_field("frame_tick", 4'(want.frame_tick), 4'(result_i.frame_tick));
          compare_field("power_off", 4'(want.power_off), 4'(result_i.power_off));
          compare_field("auto_enabled", 4'(want.auto_enabled),
                        4'(result_i.auto_enabled));
          checked++;
          if (want.mode_changed) advances++;
        end
      end
      if (poll_valid_i && !poll_stall_i) expected_q.push_back(predict_poll(poll_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bms_pkg::CFG_LONG_PRESS:  long_ms   = cfg_wdata_i[15:0];
          bms_pkg::CFG_SHORT_PRESS: short_ms  = cfg_wdata_i[15:0];
          bms_pkg::CFG_ADC_PERIOD:  adc_ms    = cfg_wdata_i[15:0];
          bms_pkg::CFG_LOW_BATTERY: low_level = cfg_wdata_i[11:0];
          bms_pkg::CFG_AUTO_SWITCH: auto_ms   = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= expected_q.size();
    checked_o     <= checked;
    advances_o    <= advances;
  end

endmodule

FILE: sim/button_mode_sequencer_test.sv
// Testbench top for the button mode sequencer: clock, reset, poll stimulus and verdict.
`timescale 1ns / 1ps

module button_mode_sequencer_test;

  localparam int unsigned PLANNED_POLLS = 1650;
  localparam int unsigned SEGMENT_POLLS = 325;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             poll_valid = 1'b0;
  logic                             poll_stall;
  bms_pkg::poll_t                   poll       = '0;
  logic                             res_valid;
  logic                             res_stall  = 1'b0;
  bms_pkg::result_t                 res;
  logic                             cfg_we     = 1'b0;
  logic [bms_pkg::CfgIdxWidth-1:0]  cfg_idx    = '0;
  logic [bms_pkg::CfgDataWidth-1:0] cfg_wdata  = '0;

  int unsigned mismatches, outstanding, checked, advances;

  // Settings the stimulus has to respect, mirrored from the last register writes.
  logic [31:0] long_cfg  = 32'd1000;
  logic [31:0] short_cfg = 32'd50;
  logic [31:0] level_cfg = 32'd2700;

  // Poll time and button level as the block last saw them.
  logic [31:0] clock_ms  = '0;
  logic        btn_level = 1'b0;

  int unsigned polls_sent    = 0;
  int unsigned settings_used = 1;
  int unsigned send_idle     = 0;
  int unsigned recv_idle     = 0;

  always #5 clk = ~clk;

  // Result side: stall at the rate of the current idle profile.
  always @(posedge clk) res_stall <= ($urandom_range(99, 0) < recv_idle);

  button_mode_sequencer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (poll_valid),
    .in_stall_o  (poll_stall),
    .in_data_i   (poll),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  button_mode_sequencer_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .poll_valid_i   (poll_valid),
    .poll_stall_i   (poll_stall),
    .poll_i         (poll),
    .result_valid_i (res_valid),
    .result_stall_i (res_stall),
    .result_i       (res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .checked_o      (checked),
    .advances_o     (advances)
  );

  // Advance time by dt and offer one poll; return once the transaction is accepted.
  task automatic send_poll(input logic [31:0] dt, input logic btn, input logic rdy,
                           input logic [11:0] smp);
    clock_ms = clock_ms + dt;
    btn_level = btn;
    // Pick the idle profile from the position in the run: sender-light first,
    // then receiver-light, then a stretch with no gaps at all.
    if (polls_sent < PLANNED_POLLS / 3) begin
      send_idle = 23;
      recv_idle <= 46;
    end else if (polls_sent < 2 * PLANNED_POLLS / 3) begin
      send_idle = 46;
      recv_idle <= 23;
    end else begin
      send_idle = 0;
      recv_idle <= 0;
    end
    while ($urandom_range(99, 0) < send_idle) begin
      poll_valid <= 1'b0;
      @(posedge clk);
    end
    poll_valid <= 1'b1;
    poll       <= '{now_ms: clock_ms, button_level: btn, adc_ready: rdy, adc_sample: smp};
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    polls_sent++;
  endtask

  // Offer a battery sample half the time; offered samples never read as low,
  // so only the closing shutdown can halt the block.
  task automatic send_poll_noisy(input logic [31:0] dt, input logic btn);
    logic rdy;
    rdy = 1'($urandom_range(1, 0));
    send_poll(dt, btn, rdy, rdy ? 12'($urandom_range(4095, level_cfg)) : 12'($urandom()));
  endtask

  // Mostly short idle gaps, now and then a jump far across the time range.
  function automatic logic [31:0] gap_ms();
    if ($urandom_range(99, 0) < 5) return $urandom();
    return $urandom_range(120, 0);
  endfunction

  // One press: the button goes down, is polled while held, and comes back up.
  // Holds never pass the long limit; a late release comes with no hold polls.
  task automatic press_cycle();
    logic [31:0] span, off, next_off, cap;
    int unsigned kind, holds;
    cap  = (short_cfg < long_cfg) ? short_cfg : long_cfg;
    kind = $urandom_range(99, 0);
    if (kind < 60 && short_cfg < long_cfg) begin
      span = $urandom_range(long_cfg, short_cfg + 1);
    end else if (kind < 75) begin
      span = $urandom_range(cap, 0);
    end else if (kind < 88) begin
      case ($urandom_range(2, 0))
        0:       span = short_cfg;
        1:       span = short_cfg + 1;
        default: span = long_cfg;
      endcase
    end else begin
      span = long_cfg + 1 + $urandom_range(5000, 0);
    end
    holds = (span > long_cfg) ? 0 : $urandom_range(4, 0);
    send_poll_noisy(gap_ms(), 1'b1);
    off = '0;
    repeat (holds) begin
      next_off = $urandom_range(span, off);
      send_poll_noisy(next_off - off, 1'b1);
      off = next_off;
    end
    send_poll_noisy(span - off, 1'b0);
  endtask

  task automatic run_segment();
    int unsigned stop;
    stop = polls_sent + SEGMENT_POLLS;
    while (polls_sent < stop) begin
      repeat ($urandom_range(3, 0)) send_poll_noisy(gap_ms(), 1'b0);
      press_cycle();
    end
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    poll_valid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 5000 && outstanding != 0; i++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all five registers back to back while the block is idle.
  task automatic apply_settings(input logic [15:0] lp, input logic [15:0] sp,
                                input logic [15:0] ap, input logic [11:0] lb,
                                input logic [31:0] asw);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= bms_pkg::CFG_LONG_PRESS;
    cfg_wdata <= 32'(lp);
    @(posedge clk);
    cfg_idx   <= bms_pkg::CFG_SHORT_PRESS;
    cfg_wdata <= 32'(sp);
    @(posedge clk);
    cfg_idx   <= bms_pkg::CFG_ADC_PERIOD;
    cfg_wdata <= 32'(ap);
    @(posedge clk);
    cfg_idx   <= bms_pkg::CFG_LOW_BATTERY;
    cfg_wdata <= 32'(lb);
    @(posedge clk);
    cfg_idx   <= bms_pkg::CFG_AUTO_SWITCH;
    cfg_wdata <= asw;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    long_cfg  = 32'(lp);
    short_cfg = 32'(sp);
    level_cfg = 32'(lb);
    settings_used++;
  endtask

  initial begin
    string       ending;
    logic [15:0] lp;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, auto switching still on: battery check right at the
    // threshold, auto advances, one across the wrap of the millisecond counter.
    send_poll(32'd0, 1'b0, 1'b0, 12'hFFF);
    send_poll(32'd44999, 1'b0, 1'b1, 12'd2700);
    send_poll(32'd1, 1'b0, 1'b1, 12'hA8C);
    send_poll(32'd45000, 1'b0, 1'b1, 12'hFFF);
    send_poll(32'hFFFF_FF00 - clock_ms, 1'b0, 1'b0, 12'h000);
    send_poll(32'd45000, 1'b0, 1'b0, 12'h555);

    // Shortest auto interval: advance on every poll through the remaining modes and back to zero.
    apply_settings(16'd1000, 16'd50, 16'd500, 12'd2700, 32'd1);
    repeat (5) send_poll(32'd1, 1'b0, 1'b0, 12'hAAA);

    // Press edges: exactly the short minimum, held exactly to the long limit,
    // one past the minimum, released too late, and barely pressed.
    send_poll(32'd7, 1'b1, 1'b0, 12'h000);
    send_poll(32'd50, 1'b0, 1'b0, 12'h000);
    send_poll(32'd3, 1'b1, 1'b0, 12'h000);
    send_poll(32'd1000, 1'b1, 1'b0, 12'h000);
    send_poll(32'd0, 1'b0, 1'b0, 12'h000);
    send_poll(32'd9, 1'b1, 1'b0, 12'h000);
    send_poll(32'd51, 1'b0, 1'b0, 12'h000);
    send_poll(32'd9, 1'b1, 1'b0, 12'h000);
    send_poll(32'd1001, 1'b0, 1'b0, 12'h000);
    send_poll(32'd9, 1'b1, 1'b0, 12'h000);
    send_poll(32'd1, 1'b0, 1'b0, 12'h000);

    // Random press traffic under a range of settings, extremes first.
    apply_settings(16'd1000, 16'd50, 16'd500, 12'd2700, 32'd45000);
    run_segment();
    apply_settings(16'hFFFF, 16'd0, 16'd1, 12'd0, 32'd1);
    run_segment();
    apply_settings(16'd1, 16'd0, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF);
    run_segment();
    lp = 16'($urandom_range(3000, 2));
    apply_settings(lp, 16'($urandom_range(lp - 1, 0)), 16'($urandom_range(800, 1)),
                   12'($urandom_range(4095, 0)), $urandom());
    run_segment();
    // Minimum above the long limit: no press can ever count.
    apply_settings(16'd100, 16'hFFFF, 16'($urandom_range(65535, 1)),
                   12'($urandom_range(4095, 0)), $urandom_range(200000, 1));
    run_segment();

    // Shut down once, by one of the two paths, then poke the halted block.
    apply_settings(16'd1000, 16'd50, 16'd1, 12'd2048, 32'd45000);
    if ($urandom_range(1, 0) == 1) begin
      ending = "a long hold";
      send_poll(gap_ms(), 1'b1, 1'b0, 12'h000);
      send_poll(32'd1001, 1'b1, 1'b0, 12'h000);
    end else begin
      ending = "a low battery reading on a counted release";
      send_poll(32'd10, 1'b1, 1'b0, 12'h000);
      send_poll(32'd100, 1'b0, 1'b1, 12'($urandom_range(2047, 0)));
    end
    repeat (4) begin
      send_poll($urandom(), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                12'($urandom()));
    end

    wait_drained();
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    $display("covered %0d polls under %0d register settings, %0d results checked",
             polls_sent, settings_used, checked);
    $display("%0d mode advances predicted; shutdown reached through %s", advances, ending);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/bms_pkg.sv
hdl/bms_step.sv
hdl/button_mode_sequencer.sv
sim/button_mode_sequencer_checker.sv
sim/button_mode_sequencer_test.sv
